// ===== rtl/core/clle_pkg.sv =====
// Shared types and codes for the cursor linked-list engine.
// No dependencies; clle_seq, the engine and the testbench refer to it by scoped names.
package clle_pkg;

  typedef enum logic [2:0] {
    OP_ALLOC    = 3'd0,
    OP_INSERT   = 3'd1,
    OP_DELETE   = 3'd2,
    OP_FIND     = 3'd3,
    OP_FINDPREV = 3'd4,
    OP_ISEMPTY  = 3'd5,
    OP_ISLAST   = 3'd6
  } op_t;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] element;
    logic [5:0] list_head;
    logic [5:0] position;
  } in_item_t;

  typedef struct packed {
    logic [5:0] result_cell;
    logic       result_flag;
    logic       status;
  } out_item_t;

  typedef enum logic [4:0] {
    ST_INIT,
    ST_IDLE,
    ST_RED,
    ST_A_RD0,
    ST_A_C,
    ST_A_W0,
    ST_A_W1,
    ST_I_R,
    ST_I_W0,
    ST_I_W1,
    ST_Q_RD,
    ST_Q_DAT,
    ST_W_CHK,
    ST_W_CMP,
    ST_D_G0,
    ST_D_G1,
    ST_D_G2,
    ST_D_G3,
    ST_D_G4,
    ST_DONE
  } state_t;

endpackage

// ===== rtl/core/clle_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module clle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/clle_seq.sv =====
// Sequencer and walk datapath of the linked-list engine: link and element
// RAMs, one compare unit, a cell counter. Depends on clle_pkg and clle_ram.
module clle_seq #(
  parameter int SPACE_SIZE = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  clle_pkg::in_item_t  cmd,
  output logic                ready,
  output logic                res_valid,
  input  logic                res_ready,
  output clle_pkg::out_item_t res
);

  localparam int AW = (SPACE_SIZE > 1) ? $clog2(SPACE_SIZE) : 1;
  localparam int SW = $clog2(SPACE_SIZE + 1);
  localparam logic [12:0]   NSZ   = 13'(SPACE_SIZE);
  localparam logic [AW-1:0] NLAST = AW'(SPACE_SIZE - 1);
  localparam logic [SW-1:0] NSTEP = SW'(SPACE_SIZE);

  clle_pkg::state_t    state_r, state_nxt;
  clle_pkg::op_t       op_r, op_nxt;
  logic [7:0]          x_r, x_nxt;
  logic [5:0]          head6_r, head6_nxt, pos6_r, pos6_nxt;
  logic [AW-1:0]       pre_r, pre_nxt, p_r, p_nxt, c_r, c_nxt, init_r, init_nxt;
  logic [SW-1:0]       steps_r, steps_nxt;
  logic                flag_r, flag_nxt;
  clle_pkg::out_item_t res_r, res_nxt;

  logic [AW-1:0] head_c, pos_c;
  logic          head_big, pos_big;
  logic          match, at_limit;

  logic          lk_we;
  logic [AW-1:0] lk_wa, lk_wd, lk_ra, lk_rd;
  logic          el_we;
  logic [AW-1:0] el_wa, el_ra;
  logic [7:0]    el_rd;

  clle_ram #(.WIDTH(AW), .DEPTH(SPACE_SIZE)) u_link (
    .clk(clk), .we(lk_we), .waddr(lk_wa), .wdata(lk_wd), .raddr(lk_ra), .rdata(lk_rd)
  );

  clle_ram #(.WIDTH(8), .DEPTH(SPACE_SIZE)) u_elem (
    .clk(clk), .we(el_we), .waddr(el_wa), .wdata(x_r), .raddr(el_ra), .rdata(el_rd)
  );

  assign head_c   = AW'(head6_r);
  assign pos_c    = AW'(pos6_r);
  assign head_big = {7'd0, head6_r} >= NSZ;
  assign pos_big  = {7'd0, pos6_r} >= NSZ;
  assign match    = (el_rd == x_r);
  assign at_limit = (steps_r >= NSTEP);

  assign ready     = (state_r == clle_pkg::ST_IDLE);
  assign res_valid = (state_r == clle_pkg::ST_DONE);
  assign res       = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= clle_pkg::ST_INIT;
      init_r  <= '0;
    end else begin
      state_r <= state_nxt;
      init_r  <= init_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    x_r     <= x_nxt;
    head6_r <= head6_nxt;
    pos6_r  <= pos6_nxt;
    pre_r   <= pre_nxt;
    p_r     <= p_nxt;
    c_r     <= c_nxt;
    steps_r <= steps_nxt;
    flag_r  <= flag_nxt;
    res_r   <= res_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    x_nxt     = x_r;
    head6_nxt = head6_r;
    pos6_nxt  = pos6_r;
    pre_nxt   = pre_r;
    p_nxt     = p_r;
    c_nxt     = c_r;
    steps_nxt = steps_r;
    flag_nxt  = flag_r;
    res_nxt   = res_r;
    init_nxt  = init_r;
    lk_we     = 1'b0;
    lk_wa     = '0;
    lk_wd     = '0;
    lk_ra     = '0;
    el_we     = 1'b0;
    el_wa     = c_r;
    el_ra     = p_r;

    case (state_r)
      clle_pkg::ST_INIT: begin
        lk_we    = 1'b1;
        lk_wa    = init_r;
        lk_wd    = (init_r == NLAST) ? '0 : init_r + AW'(1);
        init_nxt = init_r + AW'(1);
        if (init_r == NLAST) begin
          state_nxt = clle_pkg::ST_IDLE;
        end
      end
      clle_pkg::ST_IDLE: begin
        if (start) begin
          op_nxt    = clle_pkg::op_t'(cmd.op);
          x_nxt     = cmd.element;
          head6_nxt = cmd.list_head;
          pos6_nxt  = cmd.position;
          flag_nxt  = 1'b0;
          res_nxt   = '0;
          state_nxt = clle_pkg::ST_RED;
        end
      end
      clle_pkg::ST_RED: begin
        // bring indices into range, one subtract per index per cycle
        if (head_big) begin
          head6_nxt = head6_r - 6'(SPACE_SIZE);
        end
        if (pos_big) begin
          pos6_nxt = pos6_r - 6'(SPACE_SIZE);
        end
        if (!head_big && !pos_big) begin
          case (op_r)
            clle_pkg::OP_ALLOC, clle_pkg::OP_INSERT: state_nxt = clle_pkg::ST_A_RD0;
            clle_pkg::OP_DELETE, clle_pkg::OP_FIND, clle_pkg::OP_FINDPREV,
            clle_pkg::OP_ISEMPTY, clle_pkg::OP_ISLAST: state_nxt = clle_pkg::ST_Q_RD;
            default: state_nxt = clle_pkg::ST_DONE;
          endcase
        end
      end
      clle_pkg::ST_A_RD0: begin
        lk_ra     = '0;
        state_nxt = clle_pkg::ST_A_C;
      end
      clle_pkg::ST_A_C: begin
        c_nxt = lk_rd;
        lk_ra = lk_rd;
        if (lk_rd == '0) begin
          res_nxt.status = 1'b1;
          state_nxt      = clle_pkg::ST_DONE;
        end else begin
          state_nxt = clle_pkg::ST_A_W0;
        end
      end
      clle_pkg::ST_A_W0: begin
        lk_we     = 1'b1;
        lk_wa     = '0;
        lk_wd     = lk_rd;
        state_nxt = clle_pkg::ST_A_W1;
      end
      clle_pkg::ST_A_W1: begin
        lk_we = 1'b1;
        lk_wa = c_r;
        lk_wd = '0;
        res_nxt.result_cell = 6'(c_r);
        if (op_r == clle_pkg::OP_INSERT) begin
          el_we     = 1'b1;
          state_nxt = clle_pkg::ST_I_R;
        end else begin
          state_nxt = clle_pkg::ST_DONE;
        end
      end
      clle_pkg::ST_I_R: begin
        lk_ra     = pos_c;
        state_nxt = clle_pkg::ST_I_W0;
      end
      clle_pkg::ST_I_W0: begin
        lk_we     = 1'b1;
        lk_wa     = c_r;
        lk_wd     = lk_rd;
        state_nxt = clle_pkg::ST_I_W1;
      end
      clle_pkg::ST_I_W1: begin
        lk_we     = 1'b1;
        lk_wa     = pos_c;
        lk_wd     = c_r;
        state_nxt = clle_pkg::ST_DONE;
      end
      clle_pkg::ST_Q_RD: begin
        lk_ra     = (op_r == clle_pkg::OP_ISLAST) ? pos_c : head_c;
        state_nxt = clle_pkg::ST_Q_DAT;
      end
      clle_pkg::ST_Q_DAT: begin
        if (op_r == clle_pkg::OP_ISEMPTY || op_r == clle_pkg::OP_ISLAST) begin
          res_nxt.result_flag = (lk_rd == '0);
          state_nxt           = clle_pkg::ST_DONE;
        end else begin
          p_nxt     = lk_rd;
          pre_nxt   = head_c;
          steps_nxt = '0;
          state_nxt = clle_pkg::ST_W_CHK;
        end
      end
      clle_pkg::ST_W_CHK: begin
        // end of list, or step budget spent for delete / find previous
        if (p_r == '0 || (op_r != clle_pkg::OP_FIND && at_limit)) begin
          res_nxt.result_cell = (op_r == clle_pkg::OP_FINDPREV) ? 6'(pre_r) : 6'd0;
          res_nxt.result_flag = (op_r == clle_pkg::OP_DELETE) ? flag_r : 1'b0;
          state_nxt           = clle_pkg::ST_DONE;
        end else begin
          lk_ra     = p_r;
          el_ra     = p_r;
          state_nxt = clle_pkg::ST_W_CMP;
        end
      end
      clle_pkg::ST_W_CMP: begin
        if (match && op_r == clle_pkg::OP_FIND) begin
          res_nxt.result_cell = 6'(p_r);
          state_nxt           = clle_pkg::ST_DONE;
        end else if (match && op_r == clle_pkg::OP_FINDPREV) begin
          res_nxt.result_cell = 6'(pre_r);
          state_nxt           = clle_pkg::ST_DONE;
        end else if (match) begin
          // unlink p from its predecessor
          lk_we     = 1'b1;
          lk_wa     = pre_r;
          lk_wd     = lk_rd;
          flag_nxt  = 1'b1;
          state_nxt = clle_pkg::ST_D_G0;
        end else if (op_r == clle_pkg::OP_FIND && at_limit) begin
          res_nxt.result_cell = 6'd0;
          state_nxt           = clle_pkg::ST_DONE;
        end else begin
          pre_nxt   = p_r;
          p_nxt     = lk_rd;
          steps_nxt = steps_r + SW'(1);
          state_nxt = clle_pkg::ST_W_CHK;
        end
      end
      clle_pkg::ST_D_G0: begin
        lk_ra     = '0;
        state_nxt = clle_pkg::ST_D_G1;
      end
      clle_pkg::ST_D_G1: begin
        lk_we     = 1'b1;
        lk_wa     = p_r;
        lk_wd     = lk_rd;
        state_nxt = clle_pkg::ST_D_G2;
      end
      clle_pkg::ST_D_G2: begin
        lk_we     = 1'b1;
        lk_wa     = '0;
        lk_wd     = p_r;
        state_nxt = clle_pkg::ST_D_G3;
      end
      clle_pkg::ST_D_G3: begin
        lk_ra     = pre_r;
        state_nxt = clle_pkg::ST_D_G4;
      end
      clle_pkg::ST_D_G4: begin
        p_nxt     = lk_rd;
        steps_nxt = steps_r + SW'(1);
        state_nxt = clle_pkg::ST_W_CHK;
      end
      clle_pkg::ST_DONE: begin
        if (res_ready) begin
          state_nxt = clle_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = clle_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/cursor_linked_list_engine.sv =====
// Cursor linked-list engine: SPACE_SIZE cells of element + next link, free list at cell 0.
// Alloc and insert end early when the store is full; an unused op code gives an all-zero
// result; find, find previous and delete walk the list one cell at a time, after every index
// has been brought into range by subtraction.
// Throughput: one item at a time; in_ready returns as the result enters the output register.
// Reset: synchronous; afterwards an init pass over all SPACE_SIZE cells rebuilds the free-list chain.
module cursor_linked_list_engine #(
  parameter int SPACE_SIZE = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  clle_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output clle_pkg::out_item_t out_data
);

  // Sequencer side
  logic                seq_ready;
  logic                res_valid;
  logic                res_ready;
  clle_pkg::out_item_t res;

  // Output register: holds a finished item until the consumer takes it
  logic                out_valid_r;
  clle_pkg::out_item_t out_data_r;

  assign in_ready  = seq_ready;
  // the sequencer may hand over when the slot is empty or draining this cycle
  assign res_ready = !out_valid_r || out_ready;

  clle_seq #(.SPACE_SIZE(SPACE_SIZE)) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_valid && seq_ready),
    .cmd       (in_data),
    .ready     (seq_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== sim/tb_cursor_linked_list_engine.sv =====
// Self-checking testbench for cursor_linked_list_engine: directed list operations, then
// phased random traffic, checked against a shadow copy of the cell store kept here.
// Depends on clle_pkg (item structs, op codes) and the engine RTL.
module tb_cursor_linked_list_engine;

  localparam int CELLS = 64;
  localparam logic [2:0] OP_UNUSED = 3'd7;   // op code with no meaning: block returns zeros

  localparam int RANDOM_ITEMS = 1200;
  localparam int STALL_AT     = 300;   // result number after which the receiver holds off
  localparam int STALL_LEN    = 300;   // cycles of that hold-off
  localparam int IDLE_LIMIT   = 5000;  // cycles with no handshake before giving up
  localparam int TAIL_CYCLES  = 200;   // quiet time after the last result

  // traffic phases of the random part
  localparam int PH_GROW   = 0;
  localparam int PH_SHRINK = 1;
  localparam int PH_QUERY  = 2;

  logic                clk;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  clle_pkg::in_item_t  in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  clle_pkg::out_item_t out_data;

  cursor_linked_list_engine #(
    .SPACE_SIZE(CELLS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // One queued operation with the result it must produce. drain marks an item the
  // sender holds back until every earlier result has come out.
  typedef struct {
    clle_pkg::in_item_t  item;
    clle_pkg::out_item_t want;
    bit                  drain;
  } list_cmd_t;

  list_cmd_t           cmd_q [$];          // operations not yet offered to the block
  clle_pkg::out_item_t result_due_q [$];   // results of accepted items, oldest first
  logic [5:0]          hdr_q [$];          // cells handed out by alloc, used as list headers

  // Shadow store: links, elements, and which elements were ever written.
  logic [5:0]          link_tbl [CELLS];
  logic [7:0]          elem_tbl [CELLS];
  bit                  elem_set [CELLS];
  logic [5:0]          link_sv  [CELLS];
  logic [7:0]          elem_sv  [CELLS];
  bit                  set_sv   [CELLS];
  clle_pkg::out_item_t last_res;

  int n_sent = 0;
  int n_got  = 0;
  int n_err  = 0;
  int send_gap = 0;
  int recv_gap = 0;
  int quiet = 0;
  list_cmd_t cur_cmd;

  // Take the cell at the head of the free list; 0 when the list is empty.
  function automatic logic [5:0] pop_free();
    logic [5:0] c;
    c = link_tbl[0];
    if (c != '0) begin
      link_tbl[0] = link_tbl[c];
      link_tbl[c] = '0;
    end
    return c;
  endfunction

  // Apply one operation to the shadow store and give its result. Returns 0 when the
  // operation would compare an element that was never written (such a walk is outside
  // what the block promises); the caller then rolls the store back.
  function automatic bit run_list_op(input clle_pkg::in_item_t it,
                                     output clle_pkg::out_item_t res);
    logic [5:0] head, pos, pre, p, c;
    int         steps;
    bit         clean;
    clean = 1'b1;
    res   = '0;
    head  = it.list_head;
    pos   = it.position;
    case (it.op)
      clle_pkg::OP_ALLOC: begin
        c = pop_free();
        res.result_cell = c;
        res.status = (c == '0);
      end
      clle_pkg::OP_INSERT: begin
        c = pop_free();
        res.result_cell = c;
        if (c == '0) begin
          res.status = 1'b1;
        end else begin
          elem_tbl[c] = it.element;
          elem_set[c] = 1'b1;
          link_tbl[c] = link_tbl[pos];
          link_tbl[pos] = c;
        end
      end
      clle_pkg::OP_DELETE: begin
        // single pass after the header; removed cells go to the free-list head
        pre = head;
        p = link_tbl[head];
        for (steps = 0; p != '0 && steps < CELLS; steps++) begin
          if (!elem_set[p]) clean = 1'b0;
          if (elem_tbl[p] == it.element) begin
            link_tbl[pre] = link_tbl[p];
            link_tbl[p] = link_tbl[0];
            link_tbl[0] = p;
            res.result_flag = 1'b1;
            p = link_tbl[pre];
          end else begin
            pre = p;
            p = link_tbl[p];
          end
        end
      end
      clle_pkg::OP_FIND: begin
        // cut off after CELLS + 1 link reads: a cyclic list yields "none"
        p = link_tbl[head];
        steps = 0;
        while (p != '0) begin
          if (!elem_set[p]) clean = 1'b0;
          if (elem_tbl[p] == it.element) break;
          if (steps >= CELLS) begin
            p = '0;
            break;
          end
          p = link_tbl[p];
          steps++;
        end
        res.result_cell = p;
      end
      clle_pkg::OP_FINDPREV: begin
        // miss gives the last cell reached
        pre = head;
        p = link_tbl[head];
        steps = 0;
        while (p != '0) begin
          if (!elem_set[p]) clean = 1'b0;
          if (elem_tbl[p] == it.element || steps >= CELLS) break;
          pre = p;
          p = link_tbl[p];
          steps++;
        end
        res.result_cell = pre;
      end
      clle_pkg::OP_ISEMPTY: res.result_flag = (link_tbl[head] == '0);
      clle_pkg::OP_ISLAST:  res.result_flag = (link_tbl[pos] == '0);
      default: ;
    endcase
    return clean;
  endfunction

  // Predict an item and queue it, or drop it and restore the store if it is not legal.
  function automatic bit try_issue(input clle_pkg::in_item_t it, input bit drain);
    list_cmd_t cmd;
    link_sv = link_tbl;
    elem_sv = elem_tbl;
    set_sv  = elem_set;
    if (!run_list_op(it, cmd.want)) begin
      link_tbl = link_sv;
      elem_tbl = elem_sv;
      elem_set = set_sv;
      return 1'b0;
    end
    cmd.item  = it;
    cmd.drain = drain;
    cmd_q.push_back(cmd);
    last_res = cmd.want;
    return 1'b1;
  endfunction

  function automatic void put(logic [2:0] op, logic [7:0] e, logic [5:0] h, logic [5:0] p);
    clle_pkg::in_item_t it;
    it.op = op;
    it.element = e;
    it.list_head = h;
    it.position = p;
    void'(try_issue(it, 1'b0));
  endfunction

  // Random cell on the chain starting at h, h itself included. Follows links only.
  function automatic logic [5:0] pick_in_list(logic [5:0] h);
    logic [5:0] seen [$];
    logic [5:0] p;
    p = h;
    for (int i = 0; i < CELLS; i++) begin
      seen.push_back(p);
      p = link_tbl[p];
      if (p == '0) break;
    end
    return seen[$urandom_range(0, seen.size() - 1)];
  endfunction

  function automatic logic [2:0] pick_op(int phase);
    int r;
    r = $urandom_range(0, 99);
    case (phase)
      PH_GROW:
        return r < 70 ? clle_pkg::OP_INSERT : r < 80 ? clle_pkg::OP_FIND :
               r < 85 ? clle_pkg::OP_FINDPREV : r < 90 ? clle_pkg::OP_DELETE :
               r < 95 ? clle_pkg::OP_ISEMPTY : clle_pkg::OP_ISLAST;
      PH_SHRINK:
        return r < 45 ? clle_pkg::OP_DELETE : r < 65 ? clle_pkg::OP_INSERT :
               r < 75 ? clle_pkg::OP_FIND : r < 85 ? clle_pkg::OP_FINDPREV :
               r < 90 ? clle_pkg::OP_ISEMPTY : clle_pkg::OP_ISLAST;
      default:
        return r < 20 ? clle_pkg::OP_INSERT : r < 45 ? clle_pkg::OP_FIND :
               r < 65 ? clle_pkg::OP_FINDPREV : r < 75 ? clle_pkg::OP_DELETE :
               r < 85 ? clle_pkg::OP_ISEMPTY : clle_pkg::OP_ISLAST;
    endcase
  endfunction

  // Idle cycles before the next item; short windows run with no idling at all.
  function automatic int idle_draw(int k);
    if ((k % 250) < 30) return 0;
    return $urandom_range(0, 14);
  endfunction

  // Sender: offers the head of cmd_q. valid is only ever dropped after an accept, and is
  // kept high with a new payload when the next item follows back to back.
  always @(posedge clk) begin
    int gap;
    bit took;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      send_gap <= 0;
    end else begin
      took = in_valid && in_ready;
      gap  = send_gap;
      if (took) begin
        result_due_q.push_back(cur_cmd.want);
        n_sent <= n_sent + 1;
        gap = idle_draw(n_sent);
      end
      if (!in_valid || took) begin
        if (gap > 0) begin
          in_valid <= 1'b0;
          send_gap <= gap - 1;
        end else if (cmd_q.size() != 0 &&
                     (!cmd_q[0].drain || n_got == n_sent + int'(took))) begin
          cur_cmd = cmd_q.pop_front();
          in_data  <= cur_cmd.item;
          in_valid <= 1'b1;
          send_gap <= 0;
        end else begin
          in_valid <= 1'b0;
          send_gap <= 0;
        end
      end
    end
  end

  // Receiver: checks each result against the oldest expectation, then drops ready for a
  // drawn number of cycles. Once, it holds off long enough for the block to back up.
  always @(posedge clk) begin
    int                  gap;
    clle_pkg::out_item_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      recv_gap  <= 0;
    end else begin
      gap = recv_gap;
      if (out_valid && out_ready) begin
        n_got <= n_got + 1;
        if (result_due_q.size() == 0) begin
          if (n_err < 10)
            $display("unexpected result: cell %0d flag %0b status %0b",
                     out_data.result_cell, out_data.result_flag, out_data.status);
          n_err++;
        end else begin
          want = result_due_q.pop_front();
          if (out_data.result_cell !== want.result_cell ||
              out_data.result_flag !== want.result_flag ||
              out_data.status !== want.status) begin
            if (n_err < 10)
              $display({"result %0d: expected cell %0d flag %0b status %0b,",
                        " got cell %0d flag %0b status %0b"},
                       n_got, want.result_cell, want.result_flag, want.status,
                       out_data.result_cell, out_data.result_flag, out_data.status);
            n_err++;
          end
        end
        gap = (n_got + 1 == STALL_AT) ? STALL_LEN : idle_draw(n_got);
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        recv_gap  <= gap - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles with no handshake on either side.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else if (quiet == IDLE_LIMIT) begin
      $display("tb_cursor_linked_list_engine: done, errors");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    logic [5:0]         hd, c1, c2, c3, loop_c, h, c;
    clle_pkg::in_item_t cand;
    int                 phase, roll, made;
    bit                 pause;

    for (int i = 0; i < CELLS; i++) begin
      link_tbl[i] = 6'((i + 1) % CELLS);
      elem_tbl[i] = '0;
      elem_set[i] = 1'b0;
    end

    // Directed: free-list probes, one list built and queried, duplicates removed,
    // a self-linked cell walked until the step limit, and the unused op code.
    put(clle_pkg::OP_ISEMPTY, 8'h00, 6'd0, 6'd0);
    put(clle_pkg::OP_ISLAST, 8'h00, 6'd0, 6'd63);
    put(clle_pkg::OP_ALLOC, 8'hFF, 6'd63, 6'd63);
    hd = last_res.result_cell;
    hdr_q.push_back(hd);
    put(clle_pkg::OP_ISEMPTY, 8'h00, hd, 6'd0);
    put(clle_pkg::OP_FIND, 8'h00, hd, 6'd0);        // empty list: none
    put(clle_pkg::OP_FINDPREV, 8'h00, hd, 6'd0);    // empty list: the header
    put(clle_pkg::OP_DELETE, 8'h00, hd, 6'd0);      // nothing removed
    put(clle_pkg::OP_INSERT, 8'h00, hd, hd);
    c1 = last_res.result_cell;
    put(clle_pkg::OP_INSERT, 8'hFF, hd, c1);
    c2 = last_res.result_cell;
    put(clle_pkg::OP_INSERT, 8'h00, hd, c2);        // duplicate element
    c3 = last_res.result_cell;
    put(clle_pkg::OP_INSERT, 8'h5A, hd, hd);        // new front cell
    put(clle_pkg::OP_FIND, 8'h00, hd, 6'd0);
    put(clle_pkg::OP_FIND, 8'hFF, hd, 6'd0);
    put(clle_pkg::OP_FIND, 8'h33, hd, 6'd0);        // miss
    put(clle_pkg::OP_FINDPREV, 8'hFF, hd, 6'd0);
    put(clle_pkg::OP_FINDPREV, 8'h33, hd, 6'd0);    // miss: last cell
    put(clle_pkg::OP_ISLAST, 8'h00, hd, c3);
    put(clle_pkg::OP_ISLAST, 8'h00, hd, hd);
    put(clle_pkg::OP_DELETE, 8'h00, hd, 6'd0);      // removes both copies
    put(clle_pkg::OP_DELETE, 8'h00, hd, 6'd0);
    // inserting after the cell about to be taken links that cell to itself
    loop_c = link_tbl[0];
    put(clle_pkg::OP_INSERT, 8'hC3, 6'd0, loop_c);
    put(clle_pkg::OP_FIND, 8'h3C, loop_c, 6'd0);
    put(clle_pkg::OP_FINDPREV, 8'h3C, loop_c, 6'd0);
    put(clle_pkg::OP_FIND, 8'hC3, loop_c, 6'd0);
    put(OP_UNUSED, 8'hFF, 6'd63, 6'd63);

    // Random: phases that grow the lists into a full store, shrink them, or query them.
    // Most items work on known headers and cells on their chains; a few are noise.
    // The first random item waits for the block to drain.
    made  = 0;
    pause = 1'b1;
    while (made < RANDOM_ITEMS) begin
      phase = $urandom_range(PH_GROW, PH_QUERY);
      repeat ($urandom_range(40, 120)) begin
        roll = $urandom_range(0, 99);
        cand.element = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
        cand.list_head = 6'($urandom);
        cand.position = 6'($urandom);
        if (roll < 6) begin
          cand.op = 3'($urandom);
        end else if (hdr_q.size() == 0 ||
                     (hdr_q.size() < 8 && roll < (hdr_q.size() < 3 ? 25 : 8))) begin
          cand.op = clle_pkg::OP_ALLOC;
        end else begin
          h = hdr_q[$urandom_range(0, hdr_q.size() - 1)];
          c = pick_in_list(h);
          cand.op = pick_op(phase);
          cand.list_head = h;
          cand.position = c;
          // aim most searches and deletes at an element that is on the list
          if ((cand.op == clle_pkg::OP_FIND || cand.op == clle_pkg::OP_FINDPREV ||
               cand.op == clle_pkg::OP_DELETE) &&
              c != h && elem_set[c] && $urandom_range(0, 9) < 6)
            cand.element = elem_tbl[c];
        end
        if (try_issue(cand, pause)) begin
          pause = 1'b0;
          if (cand.op != OP_UNUSED) made++;
          if (cand.op == clle_pkg::OP_ALLOC && last_res.status == 1'b0 && hdr_q.size() < 8)
            hdr_q.push_back(last_res.result_cell);
        end
      end
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // sample between edges so that the driver's updates have settled
    while (cmd_q.size() != 0 || in_valid || n_got != n_sent) @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (n_err == 0 && result_due_q.size() == 0)
      $display("tb_cursor_linked_list_engine: done, clean");
    else
      $display("tb_cursor_linked_list_engine: done, errors");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/clle_pkg.sv
rtl/core/clle_ram.sv
rtl/core/clle_seq.sv
rtl/core/cursor_linked_list_engine.sv
sim/tb_cursor_linked_list_engine.sv
